FILE: rtl/hcbd_pkg.sv
// Package for the header-checked byte stream decryptor.
// Holds request/result payload types, phase and status codes, header constants.
// No dependencies.
`default_nettype none

package hcbd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } req_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_HDR_SHORT   = 2'd1,
        ST_BAD_MAGIC   = 2'd2,
        ST_PLAIN_SHORT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        status_t    out_status;
        logic       out_end;
    } res_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COPY    = 2'd1,
        PH_DECRYPT = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    localparam int          IDX_W      = 4;
    localparam int          LEN_W      = 24;
    localparam logic [3:0]  LEN_IDX0   = 4'hC;
    localparam logic [3:0]  LEN_IDX1   = 4'hD;
    localparam logic [3:0]  LEN_IDX2   = 4'hE;
    localparam logic [3:0]  KEY_IDX    = 4'hF;
    localparam logic [7:0]  MAGIC2     = 8'hFE;

    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0:    v = 8'h69;
            2'd1:    v = 8'h66;
            2'd2:    v = 8'h6D;
            default: v = 8'h74;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/header_checked_byte_stream_decryptor.sv
// Top level of the header-checked byte stream decryptor.
// Request register, hcbd_core decode step, result register. Depends on hcbd_pkg, hcbd_core.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-----------------------------------------
//  request | req_valid  | req_stall  | req_data : hcbd_pkg::req_t (byte, last)
//  result  | res_valid  | res_stall  | res_data : hcbd_pkg::res_t
//
// One request per cycle while no result stalls; the result is registered after the request.
// Header bytes and dropped bytes give no result unless last; every other byte gives one.
// Reset returns the decoder to the start of a file and empties both registers.
// A stalled result holds the request register; req_stall rises only then.
`default_nettype none

module header_checked_byte_stream_decryptor (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire hcbd_pkg::req_t req_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output hcbd_pkg::res_t     res_data
);

    logic              in_valid_reg, in_valid_next;
    hcbd_pkg::req_t    in_data_reg;
    logic              out_valid_reg, out_valid_next;
    hcbd_pkg::res_t    out_data_reg;
    logic              out_free;
    logic              process;
    logic              accept;
    hcbd_pkg::res_t    core_res;
    logic              core_has;

    assign out_free  = !out_valid_reg || !res_stall;
    assign process   = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    hcbd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (process),
        .req     (in_data_reg),
        .res     (core_res),
        .res_has (core_has)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = process && core_has;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= req_data;
        if (out_free)
            out_data_reg <= core_res;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    a_mid_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.out_end |-> res_data.out_has_byte)
        else $error("result without end carries no byte");

    a_mid_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.out_end |-> res_data.out_status == hcbd_pkg::ST_OK)
        else $error("status set on a result without end");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.out_has_byte |-> res_data.out_byte == 8'd0)
        else $error("byte field nonzero without payload");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg && out_valid_reg && res_stall)
        else $error("request stalled with room to advance");

endmodule

`default_nettype wire

FILE: rtl/hcbd_core.sv
// Per-file state and single-step decode of one request byte.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire hcbd_pkg::req_t req,
    output hcbd_pkg::res_t     res,
    output logic               res_has
);

    hcbd_pkg::phase_t                  phase_reg, phase_next;
    logic [hcbd_pkg::IDX_W-1:0]        header_index_reg, header_index_next;
    logic                              magic_good_reg, magic_good_next;
    logic [hcbd_pkg::LEN_W-1:0]        plain_remaining_reg, plain_remaining_next;
    logic [7:0]                        decrypt_key_reg, decrypt_key_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= hcbd_pkg::PH_HEADER;
            header_index_reg    <= '0;
            magic_good_reg      <= 1'b1;
            plain_remaining_reg <= '0;
            decrypt_key_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            header_index_reg    <= header_index_next;
            magic_good_reg      <= magic_good_next;
            plain_remaining_reg <= plain_remaining_next;
            decrypt_key_reg     <= decrypt_key_next;
        end
    end

    always_comb
    begin
        logic [7:0]                 b;
        logic [hcbd_pkg::LEN_W-1:0] rem_dec;
        b                    = req.in_byte;
        rem_dec              = plain_remaining_reg - 1'b1;
        phase_next           = phase_reg;
        header_index_next    = header_index_reg;
        magic_good_next      = magic_good_reg;
        plain_remaining_next = plain_remaining_reg;
        decrypt_key_next     = decrypt_key_reg;
        res                  = '0;
        res.out_status       = hcbd_pkg::ST_OK;
        res_has              = 1'b0;

        case (phase_reg)
            hcbd_pkg::PH_HEADER:
            begin
                header_index_next = header_index_reg + 1'b1;
                case (header_index_reg) inside
                    [4'd0:4'd3]:
                        if (b != hcbd_pkg::magic_byte(header_index_reg[1:0]))
                            magic_good_next = 1'b0;
                    [4'd8:4'd11]:
                        if (b != hcbd_pkg::MAGIC2)
                            magic_good_next = 1'b0;
                    hcbd_pkg::LEN_IDX0:
                        plain_remaining_next = plain_remaining_reg | {16'd0, b};
                    hcbd_pkg::LEN_IDX1:
                        plain_remaining_next = plain_remaining_reg | {8'd0, b, 8'd0};
                    hcbd_pkg::LEN_IDX2:
                        plain_remaining_next = plain_remaining_reg | {b, 16'd0};
                    default: ;
                endcase
                if (header_index_reg == hcbd_pkg::KEY_IDX)
                begin
                    decrypt_key_next  = b - 8'd1;
                    header_index_next = '0;
                    if (!magic_good_reg)
                        phase_next = hcbd_pkg::PH_DROP;
                    else if (plain_remaining_reg == '0)
                        phase_next = hcbd_pkg::PH_DECRYPT;
                    else
                        phase_next = hcbd_pkg::PH_COPY;
                    if (req.in_last)
                    begin
                        res_has     = 1'b1;
                        res.out_end = 1'b1;
                        if (!magic_good_reg)
                            res.out_status = hcbd_pkg::ST_BAD_MAGIC;
                        else if (plain_remaining_reg != '0)
                            res.out_status = hcbd_pkg::ST_PLAIN_SHORT;
                        else
                            res.out_status = hcbd_pkg::ST_OK;
                    end
                end
                else if (req.in_last)
                begin
                    res_has        = 1'b1;
                    res.out_end    = 1'b1;
                    res.out_status = hcbd_pkg::ST_HDR_SHORT;
                end
            end
            hcbd_pkg::PH_COPY:
            begin
                plain_remaining_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = hcbd_pkg::PH_DECRYPT;
                res_has          = 1'b1;
                res.out_byte     = b;
                res.out_has_byte = 1'b1;
                res.out_end      = req.in_last;
                if (req.in_last && rem_dec != '0)
                    res.out_status = hcbd_pkg::ST_PLAIN_SHORT;
            end
            hcbd_pkg::PH_DECRYPT:
            begin
                res_has          = 1'b1;
                res.out_byte     = decrypt_key_reg - b;
                res.out_has_byte = 1'b1;
                res.out_end      = req.in_last;
            end
            default:
            begin
                if (req.in_last)
                begin
                    res_has        = 1'b1;
                    res.out_end    = 1'b1;
                    res.out_status = hcbd_pkg::ST_BAD_MAGIC;
                end
            end
        endcase

        if (req.in_last)
        begin
            phase_next           = hcbd_pkg::PH_HEADER;
            header_index_next    = '0;
            magic_good_next      = 1'b1;
            plain_remaining_next = '0;
            decrypt_key_next     = '0;
        end
    end

endmodule

`default_nettype wire

FILE: bench/hcbd_stream_checker.sv
// Checker for the header-checked byte stream decryptor: watches both channels,
// predicts each result from the accepted requests and compares field by field.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_stream_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_stall,
    input  wire hcbd_pkg::req_t  req_data,
    input  wire logic            res_valid,
    input  wire logic            res_stall,
    input  wire hcbd_pkg::res_t  res_data,
    input  wire logic            flush,
    output int                   fail_count,
    output int                   pending,
    output int                   results_checked,
    output int                   files_closed,
    output logic [3:0]           status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    hcbd_pkg::phase_t           ph;
    logic [3:0]                 hdr_idx;
    logic                       magic_ok;
    logic [hcbd_pkg::LEN_W-1:0] remaining;
    logic [7:0]                 key;
    hcbd_pkg::res_t             owed_results[$];

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h, at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic restart_file();
        ph = hcbd_pkg::PH_HEADER;
        hdr_idx = '0;
        magic_ok = 1'b1;
        remaining = '0;
        key = '0;
    endtask

    task automatic decrypt_step(input hcbd_pkg::req_t rq);
        hcbd_pkg::res_t r;
        bit             made;
        logic [7:0]     b;
        int             i;
        r = '0;
        made = 1'b0;
        b = rq.in_byte;
        i = int'(hdr_idx);
        case (ph)
            hcbd_pkg::PH_HEADER:
            begin
                if (i < 4 && b != hcbd_pkg::magic_byte(hdr_idx[1:0]))
                    magic_ok = 1'b0;
                if (i >= 8 && i < 12 && b != hcbd_pkg::MAGIC2)
                    magic_ok = 1'b0;
                if (i >= int'(hcbd_pkg::LEN_IDX0) && i < int'(hcbd_pkg::KEY_IDX))
                    remaining = remaining | (hcbd_pkg::LEN_W'(b)
                                << (8 * (i - int'(hcbd_pkg::LEN_IDX0))));
                if (i == int'(hcbd_pkg::KEY_IDX))
                begin
                    key = b - 8'd1;
                    if (rq.in_last)
                    begin
                        made = 1'b1;
                        r.out_end = 1'b1;
                        r.out_status = !magic_ok ? hcbd_pkg::ST_BAD_MAGIC
                                     : (remaining != '0 ? hcbd_pkg::ST_PLAIN_SHORT
                                                        : hcbd_pkg::ST_OK);
                    end
                    ph = !magic_ok ? hcbd_pkg::PH_DROP
                       : (remaining == '0 ? hcbd_pkg::PH_DECRYPT : hcbd_pkg::PH_COPY);
                    hdr_idx = '0;
                end
                else
                begin
                    hdr_idx = hdr_idx + 4'd1;
                    if (rq.in_last)
                    begin
                        made = 1'b1;
                        r.out_end = 1'b1;
                        r.out_status = hcbd_pkg::ST_HDR_SHORT;
                    end
                end
            end
            hcbd_pkg::PH_COPY:
            begin
                remaining = remaining - 1'b1;
                if (remaining == '0)
                    ph = hcbd_pkg::PH_DECRYPT;
                made = 1'b1;
                r.out_byte = b;
                r.out_has_byte = 1'b1;
                if (rq.in_last)
                begin
                    r.out_end = 1'b1;
                    r.out_status = remaining != '0 ? hcbd_pkg::ST_PLAIN_SHORT
                                                   : hcbd_pkg::ST_OK;
                end
            end
            hcbd_pkg::PH_DECRYPT:
            begin
                made = 1'b1;
                r.out_byte = key - b;
                r.out_has_byte = 1'b1;
                r.out_end = rq.in_last;
            end
            default:
            begin
                if (rq.in_last)
                begin
                    made = 1'b1;
                    r.out_end = 1'b1;
                    r.out_status = hcbd_pkg::ST_BAD_MAGIC;
                end
            end
        endcase
        if (made)
            owed_results.push_back(r);
        if (rq.in_last)
            restart_file();
    endtask

    task automatic check_result(input hcbd_pkg::res_t got);
        hcbd_pkg::res_t want;
        if (owed_results.size() == 0)
        begin
            note_mismatch("result with nothing owed", int'(got), 0);
            return;
        end
        want = owed_results.pop_front();
        if (got.out_byte !== want.out_byte)
            note_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
        if (got.out_has_byte !== want.out_has_byte)
            note_mismatch("out_has_byte", int'(got.out_has_byte), int'(want.out_has_byte));
        if (got.out_status !== want.out_status)
            note_mismatch("out_status", int'(got.out_status), int'(want.out_status));
        if (got.out_end !== want.out_end)
            note_mismatch("out_end", int'(got.out_end), int'(want.out_end));
        results_checked++;
        if (want.out_end)
        begin
            files_closed++;
            status_seen[int'(want.out_status)] = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_file();
            owed_results.delete();
            fail_count = 0;
            pending = 0;
            results_checked = 0;
            files_closed = 0;
            status_seen = '0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            if (req_valid && !req_stall)
                decrypt_step(req_data);
            if (flush && owed_results.size() != 0)
            begin
                note_mismatch("results never delivered", 0, owed_results.size());
                owed_results.delete();
            end
            pending = owed_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_header_checked_byte_stream_decryptor.sv
// Top of the decryptor bench: clock, reset, file stimulus and receiver stalls.
// Instantiates header_checked_byte_stream_decryptor and hcbd_stream_checker.
// Depends on hcbd_pkg.
`default_nettype none

module tb_header_checked_byte_stream_decryptor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_PCT       = 32;
    localparam int          HOLDOFF_CYCLES = 250;
    localparam int          STALL_LIMIT    = 3000;
    localparam int          ITEM_TARGET    = 800;
    localparam int          DRAIN_CYCLES   = 8;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    hcbd_pkg::req_t req_data;
    logic           res_valid;
    logic           res_stall;
    hcbd_pkg::res_t res_data;
    logic           flush;
    int             fail_count;
    int             pending;
    int             results_checked;
    int             files_closed;
    logic [3:0]     status_seen;

    bit         calm;
    bit         hold_request;
    int         bytes_sent;
    int         files_sent;
    int         stall_run;
    logic [7:0] file_q[$];

    header_checked_byte_stream_decryptor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    hcbd_stream_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_data        (req_data),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_data        (res_data),
        .flush           (flush),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .files_closed    (files_closed),
        .status_seen     (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_byte(input logic [7:0] b, input logic l);
        hcbd_pkg::req_t r;
        r.in_byte = b;
        r.in_last = l;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_q[k])
            push_byte(file_q[k], k == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic add_header(input logic [23:0] len, input logic [7:0] k);
        for (int j = 0; j < 4; j++)
            file_q.push_back(hcbd_pkg::magic_byte(2'(j)));
        repeat (4) file_q.push_back(8'($urandom));
        repeat (4) file_q.push_back(hcbd_pkg::MAGIC2);
        file_q.push_back(len[7:0]);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[23:16]);
        file_q.push_back(k);
    endtask

    task automatic add_random(input int n);
        repeat (n) file_q.push_back(8'($urandom));
    endtask

    task automatic build_file();
        int          pick;
        int          n;
        int          pos;
        logic [23:0] len;
        pick = $urandom_range(99);
        file_q.delete();
        if (pick < 45)
        begin
            len = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom_range(12, 1));
            add_header(len, 8'($urandom));
            add_random(int'(len) + $urandom_range(12));
        end
        else if (pick < 60)
        begin
            len = ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(30, 2));
            if (len == 24'd0)
                len = 24'd1;
            add_header(len, 8'($urandom));
            n = (len > 24'd16) ? 16 : int'(len);
            add_random($urandom_range(n - 1));
        end
        else if (pick < 72)
        begin
            add_header(24'($urandom), 8'($urandom));
            n = $urandom_range(15, 1);
            while (file_q.size() > n)
                void'(file_q.pop_back());
        end
        else if (pick < 87)
        begin
            add_header(24'($urandom_range(8)), 8'($urandom));
            pos = $urandom_range(7);
            pos = (pos < 4) ? pos : pos + 4;
            file_q[pos] = file_q[pos] ^ 8'($urandom_range(255, 1));
            add_random($urandom_range(10));
        end
        else
            add_random($urandom_range(40, 1));
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            stall_run <= 0;
        else
            stall_run <= stall_run + 1;
        if (stall_run >= STALL_LIMIT)
        begin
            $display("Watchdog: no traffic for %0d cycles", stall_run);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        flush = 1'b0;
        calm = 1'b0;
        hold_request = 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        file_q.delete();
        file_q.push_back(8'hFF);
        send_file();
        file_q.delete();
        add_header(24'd1, 8'h00);
        file_q.push_back(8'h00);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        send_file();

        while (bytes_sent < ITEM_TARGET)
        begin
            calm = (files_sent >= 12 && files_sent < 18);
            if (files_sent == 6)
            begin
                hold_request = 1'b1;
                file_q.delete();
                add_header(24'd40, 8'($urandom));
                add_random(50);
            end
            else
                build_file();
            send_file();
            if (files_sent == 25 || $urandom_range(19) == 0)
            begin
                req_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
            end
        end

        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        flush <= 1'b1;
        @(negedge clk);

        $display("Sent %0d files in %0d request bytes; %0d results checked, %0d file ends.",
                 files_sent, bytes_sent, results_checked, files_closed);
        $display("End codes seen (plain short, bad magic, header short, ok): %b", status_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/hcbd_pkg.sv
rtl/hcbd_core.sv
rtl/header_checked_byte_stream_decryptor.sv
bench/hcbd_stream_checker.sv
bench/tb_header_checked_byte_stream_decryptor.sv
